// ===== src/pfgs_pkg.sv =====
// pfgs_pkg: shared widths, codes, command/status types and constant tables
// for the potential-field grid stepper; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pfgs_pkg;

	// payload widths fixed by the interface
	localparam int XYW    = 6;
	localparam int REQW   = 2;
	localparam int SLOTW  = 3;
	localparam int DIRW   = 3;
	localparam int STW    = 3;
	localparam int CNTRW  = 3;
	localparam int RADW   = 14;
	localparam int CFG_IW = 2;
	localparam int CFG_DW = 14;

	// fixed-point widths: Q8.40 potential, 42-bit attraction numerator
	localparam int PTW = 49;
	localparam int QW  = 42;
	localparam int RW  = 41;

	localparam logic [QW-1:0]  ATTR_NUM = 42'd2748779069440;
	localparam logic [PTW-1:0] GOAL_POT = 49'h1_8000_0000_0000;

	// request codes
	localparam logic [REQW-1:0] REQ_STEP    = 2'd0;
	localparam logic [REQW-1:0] REQ_RESTART = 2'd1;
	localparam logic [REQW-1:0] REQ_OBST    = 2'd2;

	// result status codes
	localparam logic [STW-1:0] ST_MOVED   = 3'd0;
	localparam logic [STW-1:0] ST_ON_GOAL = 3'd1;
	localparam logic [STW-1:0] ST_AT_GOAL = 3'd2;
	localparam logic [STW-1:0] ST_STUCK   = 3'd3;
	localparam logic [STW-1:0] ST_ACK     = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IW-1:0] CFG_GOAL_X = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_GOAL_Y = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_OBS_N  = 2'd2;
	localparam logic [CFG_IW-1:0] CFG_RADIUS = 2'd3;

	// configuration reset values
	localparam logic [XYW-1:0]   RST_GOAL   = 6'd63;
	localparam logic [CNTRW-1:0] RST_OBS_N  = 3'd6;
	localparam logic [RADW-1:0]  RST_RADIUS = 14'd25;

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_CLEAR,
		OP_VIS_RD,
		OP_MARK,
		OP_BLK,
		OP_NB,
		OP_DIV,
		OP_REP,
		OP_PICK,
		OP_EMIT_ACK,
		OP_EMIT_GOAL,
		OP_FIN
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   cnt_clr;
		logic   mark;
	} dp_cmd_t;

	typedef struct packed {
		logic [REQW-1:0] req;
		logic            at_goal;
		logic            cnt_done;
		logic            no_obs;
		logic            nb_open;
		logic            nb_goal;
		logic            nb_last;
	} dp_sts_t;

	// neighbor offsets: 0 E, 1 NE, 2 N, 3 NW, 4 W, 5 SW, 6 S, 7 SE
	function automatic logic signed [1:0] dir_dx(input logic [DIRW-1:0] k);
		logic signed [1:0] r;
		unique case (k)
			3'd0, 3'd1, 3'd7: r = 2'sd1;
			3'd2, 3'd6:       r = 2'sd0;
			default:          r = -2'sd1;
		endcase
		return r;
	endfunction

	function automatic logic signed [1:0] dir_dy(input logic [DIRW-1:0] k);
		logic signed [1:0] r;
		unique case (k)
			3'd1, 3'd2, 3'd3: r = 2'sd1;
			3'd0, 3'd4:       r = 2'sd0;
			default:          r = -2'sd1;
		endcase
		return r;
	endfunction

	// repulsion for squared distances up to nine
	function automatic logic [RW-1:0] rep_lookup(input logic [3:0] r2);
		logic [RW-1:0] r;
		unique case (r2)
			4'd1:    r = 41'd1221679586418;
			4'd2:    r = 41'd384022551335;
			4'd4:    r = 41'd76354974151;
			4'd5:    r = 41'd35648129906;
			4'd8:    r = 41'd1123840290;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/pfgs_if.sv =====
// pfgs channel interfaces: step item, result item and configuration write
// depends on pfgs_pkg for payload widths
`timescale 1ns / 1ps
`default_nettype none

interface pfgs_item_if;
	logic                        valid;
	logic                        ready;
	logic [pfgs_pkg::REQW-1:0]   req_type;
	logic [pfgs_pkg::XYW-1:0]    pos_x;
	logic [pfgs_pkg::XYW-1:0]    pos_y;
	logic [pfgs_pkg::SLOTW-1:0]  slot;
	modport source (output valid, req_type, pos_x, pos_y, slot, input ready);
	modport sink (input valid, req_type, pos_x, pos_y, slot, output ready);
endinterface

interface pfgs_result_if;
	logic                       valid;
	logic                       ready;
	logic [pfgs_pkg::XYW-1:0]   cur_x;
	logic [pfgs_pkg::XYW-1:0]   cur_y;
	logic [pfgs_pkg::DIRW-1:0]  direction;
	logic [pfgs_pkg::STW-1:0]   status;
	modport source (output valid, cur_x, cur_y, direction, status, input ready);
	modport sink (input valid, cur_x, cur_y, direction, status, output ready);
endinterface

interface pfgs_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [pfgs_pkg::CFG_IW-1:0]  index;
	logic [pfgs_pkg::CFG_DW-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/pfgs_ram.sv =====
// pfgs_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pfgs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== src/pfgs_datapath.sv =====
// pfgs_datapath: position, obstacle table, visited-row ram, blocking scan,
// attraction divider, repulsion accumulator and best-neighbor selection
// depends on pfgs_pkg and pfgs_ram
`timescale 1ns / 1ps
`default_nettype none

module pfgs_datapath #(
	parameter int GRID_SIZE     = 64,
	parameter int MAX_OBSTACLES = 6
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire pfgs_pkg::dp_cmd_t           cmd,
	output pfgs_pkg::dp_sts_t                sts,
	input  wire logic [pfgs_pkg::REQW-1:0]   in_req,
	input  wire logic [pfgs_pkg::XYW-1:0]    in_x,
	input  wire logic [pfgs_pkg::XYW-1:0]    in_y,
	input  wire logic [pfgs_pkg::SLOTW-1:0]  in_slot,
	input  wire logic                        cfg_we,
	input  wire logic [pfgs_pkg::CFG_IW-1:0] cfg_idx,
	input  wire logic [pfgs_pkg::CFG_DW-1:0] cfg_data,
	output logic      [pfgs_pkg::XYW-1:0]    res_x,
	output logic      [pfgs_pkg::XYW-1:0]    res_y,
	output logic      [pfgs_pkg::DIRW-1:0]   res_dir,
	output logic      [pfgs_pkg::STW-1:0]    res_st
);

	localparam int XYW     = pfgs_pkg::XYW;
	localparam int CW      = $clog2(GRID_SIZE);
	localparam int MW      = (CW > XYW) ? CW : XYW;
	localparam int SW      = MW + 2;
	localparam int AW      = SW - 1;
	localparam int PW2     = 2 * AW;
	localparam int D2W     = PW2 + 1;
	localparam int LW      = D2W + 1;
	localparam int IW      = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
	localparam int OW      = $clog2(MAX_OBSTACLES + 1);
	localparam int QW      = pfgs_pkg::QW;
	localparam int PTW     = pfgs_pkg::PTW;
	localparam int RW      = pfgs_pkg::RW;
	localparam int T1      = (GRID_SIZE - 1 > QW - 1) ? GRID_SIZE - 1 : QW - 1;
	localparam int CNT_TOP = (T1 > 2 * MAX_OBSTACLES - 1) ? T1 : 2 * MAX_OBSTACLES - 1;
	localparam int CNTW    = $clog2(CNT_TOP + 1);

	typedef logic signed [SW-1:0] crd_t;

	function automatic logic [AW-1:0] abs_of(input crd_t v);
		return (v < 0) ? AW'(-v) : AW'(v);
	endfunction

	function automatic logic [PW2-1:0] mul(input logic [AW-1:0] a, input logic [AW-1:0] b);
		return PW2'(a) * PW2'(b);
	endfunction

	function automatic logic [1:0] row_of(input logic [2:0] k);
		logic [1:0] r;
		unique case (pfgs_pkg::dir_dy(k))
			2'sd1:   r = 2'd2;
			2'sd0:   r = 2'd1;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	// configuration and item state
	logic [XYW-1:0]             goal_x_q, goal_y_q;
	logic [pfgs_pkg::CNTRW-1:0] obs_cnt_q;
	logic [pfgs_pkg::RADW-1:0]  radius_q;
	logic [XYW-1:0]             obs_x_q [MAX_OBSTACLES];
	logic [XYW-1:0]             obs_y_q [MAX_OBSTACLES];
	logic [CW-1:0]              cur_x_q, cur_y_q;

	// working registers
	logic [CNTW-1:0]       cnt_q;
	logic [GRID_SIZE-1:0]  rows_q [3];
	logic [7:0]            blk_q;
	crd_t                  bdx_s1, bdy_s1;
	logic [PW2-1:0]        ba2_s1, bb2_s1, bab_s1;
	logic [D2W-1:0]        r2_q;
	logic [2:0]            k_q;
	crd_t                  nbx_q, nby_q;
	logic                  nb_open_q, nb_goal_q, hit_q;
	logic [QW-1:0]         num_q;
	logic [D2W-1:0]        rem_q, d2_q;
	logic signed [PTW-1:0] pot_q, best_pot_q;
	logic [2:0]            best_q;
	logic                  best_valid_q;
	logic [XYW-1:0]        res_x_q, res_y_q;
	logic [2:0]            res_dir_q;
	logic [2:0]            res_st_q;

	// ram port
	logic                 ram_we;
	logic [CW-1:0]        ram_waddr, ram_raddr;
	logic [GRID_SIZE-1:0] ram_wdata, ram_rdata;

	// combinational helpers
	logic [OW-1:0]   n_obs;
	logic [CNTW-1:0] last_pair;
	crd_t            cx_s, cy_s, gx_s, gy_s, nb_x, nb_y, mv_x, mv_y, rd_row;
	crd_t            ox_s, oy_s, bdx_c, bdy_c, rdx_c, rdy_c;
	logic [IW-1:0]   oi;
	logic            nb_in, nb_vis, nb_open_c, nb_goal_c;
	logic [D2W-1:0]  d2g_c, bd2_c;
	logic [LW-1:0]   tx_c, ty_c, ta2_c, tb2_c;
	logic [2:0]      sect_c;
	logic [LW-1:0]   rem_n;
	logic            qbit;
	logic [D2W-1:0]  rem_next;
	logic [QW-1:0]   num_next;
	logic            mv_goal;

	always_comb begin
		n_obs = (int'(obs_cnt_q) > MAX_OBSTACLES) ? OW'(MAX_OBSTACLES) : OW'(obs_cnt_q);
		last_pair = CNTW'({n_obs, 1'b0}) - CNTW'(1);
		cx_s = crd_t'({{(SW - CW){1'b0}}, cur_x_q});
		cy_s = crd_t'({{(SW - CW){1'b0}}, cur_y_q});
		gx_s = crd_t'({{(SW - XYW){1'b0}}, goal_x_q});
		gy_s = crd_t'({{(SW - XYW){1'b0}}, goal_y_q});
		oi = cnt_q[IW:1];
		ox_s = crd_t'({{(SW - XYW){1'b0}}, obs_x_q[oi]});
		oy_s = crd_t'({{(SW - XYW){1'b0}}, obs_y_q[oi]});

		// neighbor under test
		nb_x = cx_s + crd_t'(pfgs_pkg::dir_dx(k_q));
		nb_y = cy_s + crd_t'(pfgs_pkg::dir_dy(k_q));
		nb_in = (nb_x >= 0) && (nb_y >= 0) && (nb_x < crd_t'(GRID_SIZE))
			&& (nb_y < crd_t'(GRID_SIZE));
		nb_vis = rows_q[row_of(k_q)][nb_x[CW-1:0]];
		nb_open_c = nb_in && !nb_vis && !blk_q[k_q];
		nb_goal_c = (nb_x == gx_s) && (nb_y == gy_s);
		d2g_c = D2W'(mul(abs_of(nb_x - gx_s), abs_of(nb_x - gx_s)))
			+ D2W'(mul(abs_of(nb_y - gy_s), abs_of(nb_y - gy_s)));

		// blocking scan, second half: squared distance and sector
		bdx_c = ox_s - cx_s;
		bdy_c = oy_s - cy_s;
		bd2_c = D2W'(ba2_s1) + D2W'(bb2_s1);
		ta2_c = LW'(ba2_s1);
		tb2_c = LW'(bb2_s1);
		tx_c = tb2_c + LW'({bab_s1, 1'b0});
		ty_c = ta2_c + LW'({bab_s1, 1'b0});
		if (bdx_s1 == 0 && bdy_s1 == 0) begin
			sect_c = 3'd0;
		end else if (tx_c < ta2_c) begin
			sect_c = (bdx_s1 > 0) ? 3'd0 : 3'd4;
		end else if (ty_c < tb2_c) begin
			sect_c = (bdy_s1 > 0) ? 3'd2 : 3'd6;
		end else if (bdx_s1 > 0) begin
			sect_c = (bdy_s1 > 0) ? 3'd1 : 3'd7;
		end else begin
			sect_c = (bdy_s1 > 0) ? 3'd3 : 3'd5;
		end

		// repulsion distance
		rdx_c = nbx_q - ox_s;
		rdy_c = nby_q - oy_s;

		// one restoring division step
		rem_n = {rem_q, num_q[QW-1]};
		qbit = rem_n >= LW'(d2_q);
		rem_next = qbit ? D2W'(rem_n - LW'(d2_q)) : D2W'(rem_n);
		num_next = {num_q[QW-2:0], qbit};

		// chosen move
		mv_x = cx_s + crd_t'(pfgs_pkg::dir_dx(best_q));
		mv_y = cy_s + crd_t'(pfgs_pkg::dir_dy(best_q));
		mv_goal = (mv_x == gx_s) && (mv_y == gy_s);

		// visited-row read address, out-of-grid rows read row zero
		rd_row = cy_s + crd_t'(cnt_q) - crd_t'(1);
	end

	// ram port steering
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = cur_y_q;
		ram_wdata = rows_q[1] | (GRID_SIZE'(1) << cur_x_q);
		ram_raddr = '0;
		unique case (cmd.op)
			pfgs_pkg::OP_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = cnt_q[CW-1:0];
				ram_wdata = (cmd.mark && cnt_q[CW-1:0] == cur_y_q)
					? (GRID_SIZE'(1) << cur_x_q) : '0;
			end
			pfgs_pkg::OP_MARK: begin
				ram_we = 1'b1;
			end
			pfgs_pkg::OP_FIN: begin
				ram_we = best_valid_q;
				ram_waddr = mv_y[CW-1:0];
				ram_wdata = rows_q[row_of(best_q)] | (GRID_SIZE'(1) << mv_x[CW-1:0]);
			end
			pfgs_pkg::OP_VIS_RD: begin
				if (rd_row >= 0 && rd_row < crd_t'(GRID_SIZE)) begin
					ram_raddr = rd_row[CW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	pfgs_ram #(
		.WIDTH(GRID_SIZE),
		.DEPTH(GRID_SIZE)
	) u_visited (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// status back to the controller
	always_comb begin
		sts.req = in_req;
		sts.at_goal = (MW'(cur_x_q) == MW'(goal_x_q)) && (MW'(cur_y_q) == MW'(goal_y_q));
		sts.no_obs = (n_obs == '0);
		sts.nb_open = nb_open_q;
		sts.nb_goal = nb_goal_q;
		sts.nb_last = (k_q == 3'd7);
		unique case (cmd.op)
			pfgs_pkg::OP_CLEAR:                sts.cnt_done = (cnt_q == CNTW'(GRID_SIZE - 1));
			pfgs_pkg::OP_VIS_RD:               sts.cnt_done = (cnt_q == CNTW'(3));
			pfgs_pkg::OP_BLK, pfgs_pkg::OP_REP: sts.cnt_done = (cnt_q == last_pair);
			pfgs_pkg::OP_DIV:                  sts.cnt_done = (cnt_q == CNTW'(QW - 1));
			default:                           sts.cnt_done = 1'b0;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q <= pfgs_pkg::RST_GOAL;
			goal_y_q <= pfgs_pkg::RST_GOAL;
			obs_cnt_q <= pfgs_pkg::RST_OBS_N;
			radius_q <= pfgs_pkg::RST_RADIUS;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				pfgs_pkg::CFG_GOAL_X: goal_x_q <= cfg_data[XYW-1:0];
				pfgs_pkg::CFG_GOAL_Y: goal_y_q <= cfg_data[XYW-1:0];
				pfgs_pkg::CFG_OBS_N:  obs_cnt_q <= cfg_data[pfgs_pkg::CNTRW-1:0];
				pfgs_pkg::CFG_RADIUS: radius_q <= cfg_data[pfgs_pkg::RADW-1:0];
				default: begin
				end
			endcase
		end
	end

	// step counter, self-clearing at the end of each counted operation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.op == pfgs_pkg::OP_CLEAR || cmd.op == pfgs_pkg::OP_VIS_RD
			|| cmd.op == pfgs_pkg::OP_BLK || cmd.op == pfgs_pkg::OP_DIV
			|| cmd.op == pfgs_pkg::OP_REP) begin
			cnt_q <= sts.cnt_done ? '0 : cnt_q + CNTW'(1);
		end
	end

	// control state: position, obstacles, neighbor index, best choice
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
			k_q <= '0;
			best_valid_q <= 1'b0;
			blk_q <= '0;
			for (int i = 0; i < MAX_OBSTACLES; i++) begin
				obs_x_q[i] <= '0;
				obs_y_q[i] <= '0;
			end
		end else begin
			unique case (cmd.op)
				pfgs_pkg::OP_LOAD: begin
					k_q <= '0;
					best_valid_q <= 1'b0;
					blk_q <= '0;
					if (in_req == pfgs_pkg::REQ_RESTART) begin
						cur_x_q <= (int'(in_x) >= GRID_SIZE) ? CW'(GRID_SIZE - 1) : CW'(in_x);
						cur_y_q <= (int'(in_y) >= GRID_SIZE) ? CW'(GRID_SIZE - 1) : CW'(in_y);
					end
					if (in_req == pfgs_pkg::REQ_OBST && int'(in_slot) < MAX_OBSTACLES) begin
						obs_x_q[IW'(in_slot)] <= in_x;
						obs_y_q[IW'(in_slot)] <= in_y;
					end
				end
				pfgs_pkg::OP_BLK: begin
					if (cnt_q[0] && bd2_c < D2W'(radius_q)) begin
						blk_q[sect_c] <= 1'b1;
					end
				end
				pfgs_pkg::OP_PICK: begin
					k_q <= k_q + 3'd1;
					if (nb_open_q && !hit_q && (!best_valid_q || pot_q < best_pot_q)) begin
						best_valid_q <= 1'b1;
					end
				end
				pfgs_pkg::OP_FIN: begin
					if (best_valid_q) begin
						cur_x_q <= mv_x[CW-1:0];
						cur_y_q <= mv_y[CW-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// working payload registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			pfgs_pkg::OP_VIS_RD: begin
				if (cnt_q != '0) begin
					rows_q[2'(cnt_q - CNTW'(1))] <= ram_rdata;
				end
			end
			pfgs_pkg::OP_MARK: begin
				rows_q[1] <= rows_q[1] | (GRID_SIZE'(1) << cur_x_q);
			end
			pfgs_pkg::OP_BLK: begin
				if (!cnt_q[0]) begin
					bdx_s1 <= bdx_c;
					bdy_s1 <= bdy_c;
					ba2_s1 <= mul(abs_of(bdx_c), abs_of(bdx_c));
					bb2_s1 <= mul(abs_of(bdy_c), abs_of(bdy_c));
					bab_s1 <= mul(abs_of(bdx_c), abs_of(bdy_c));
				end
			end
			pfgs_pkg::OP_NB: begin
				nbx_q <= nb_x;
				nby_q <= nb_y;
				nb_open_q <= nb_open_c;
				nb_goal_q <= nb_goal_c;
				hit_q <= 1'b0;
				d2_q <= d2g_c;
				rem_q <= '0;
				num_q <= pfgs_pkg::ATTR_NUM + QW'(d2g_c >> 1);
				pot_q <= pfgs_pkg::GOAL_POT;
			end
			pfgs_pkg::OP_DIV: begin
				rem_q <= rem_next;
				num_q <= num_next;
				if (sts.cnt_done) begin
					pot_q <= -$signed({{(PTW - QW){1'b0}}, num_next});
				end
			end
			pfgs_pkg::OP_REP: begin
				if (!cnt_q[0]) begin
					r2_q <= D2W'(mul(abs_of(rdx_c), abs_of(rdx_c)))
						+ D2W'(mul(abs_of(rdy_c), abs_of(rdy_c)));
				end else if (r2_q == '0) begin
					hit_q <= 1'b1;
				end else if (r2_q <= D2W'(9)) begin
					pot_q <= pot_q + $signed({{(PTW - RW){1'b0}},
						pfgs_pkg::rep_lookup(r2_q[3:0])});
				end
			end
			pfgs_pkg::OP_PICK: begin
				if (nb_open_q && !hit_q && (!best_valid_q || pot_q < best_pot_q)) begin
					best_q <= k_q;
					best_pot_q <= pot_q;
				end
			end
			pfgs_pkg::OP_EMIT_ACK: begin
				res_x_q <= XYW'(cx_s);
				res_y_q <= XYW'(cy_s);
				res_dir_q <= 3'd0;
				res_st_q <= pfgs_pkg::ST_ACK;
			end
			pfgs_pkg::OP_EMIT_GOAL: begin
				res_x_q <= XYW'(cx_s);
				res_y_q <= XYW'(cy_s);
				res_dir_q <= 3'd0;
				res_st_q <= pfgs_pkg::ST_AT_GOAL;
			end
			pfgs_pkg::OP_FIN: begin
				if (best_valid_q) begin
					res_x_q <= XYW'(mv_x);
					res_y_q <= XYW'(mv_y);
					res_dir_q <= best_q;
					res_st_q <= mv_goal ? pfgs_pkg::ST_ON_GOAL : pfgs_pkg::ST_MOVED;
				end else begin
					res_x_q <= XYW'(cx_s);
					res_y_q <= XYW'(cy_s);
					res_dir_q <= 3'd0;
					res_st_q <= pfgs_pkg::ST_STUCK;
				end
			end
			default: begin
			end
		endcase
	end

	assign res_x = res_x_q;
	assign res_y = res_y_q;
	assign res_dir = res_dir_q;
	assign res_st = res_st_q;

	// neighbor index advances by one on every pick
	a_k_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == pfgs_pkg::OP_PICK) |=> (k_q == $past(k_q) + 3'd1))
		else $error("neighbor index did not advance");

	// an attraction alone is never positive
	a_attr_neg: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == pfgs_pkg::OP_DIV && sts.cnt_done) |=> (pot_q <= 0))
		else $error("attraction potential positive");

endmodule

`default_nettype wire

// ===== src/pfgs_ctrl.sv =====
// pfgs_ctrl: sequencer for clearing, restart, obstacle writes and steps;
// owns the input ready and result valid; depends on pfgs_pkg
`timescale 1ns / 1ps
`default_nettype none

module pfgs_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output pfgs_pkg::dp_cmd_t      cmd,
	input  wire pfgs_pkg::dp_sts_t sts
);

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_ACK,
		S_GOAL,
		S_VRD,
		S_MARK,
		S_BLK,
		S_NB,
		S_NBDEC,
		S_DIV,
		S_REP,
		S_PICK,
		S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   mark_q;
	logic   out_free;
	logic   accept;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// command decode
	always_comb begin
		cmd.op = pfgs_pkg::OP_NONE;
		cmd.cnt_clr = 1'b0;
		cmd.mark = mark_q;
		unique case (state_q)
			S_CLR:   cmd.op = pfgs_pkg::OP_CLEAR;
			S_IDLE: begin
				if (accept) begin
					cmd.op = pfgs_pkg::OP_LOAD;
					cmd.cnt_clr = 1'b1;
				end
			end
			S_ACK:   cmd.op = out_free ? pfgs_pkg::OP_EMIT_ACK : pfgs_pkg::OP_NONE;
			S_GOAL:  cmd.op = out_free ? pfgs_pkg::OP_EMIT_GOAL : pfgs_pkg::OP_NONE;
			S_VRD:   cmd.op = pfgs_pkg::OP_VIS_RD;
			S_MARK:  cmd.op = pfgs_pkg::OP_MARK;
			S_BLK:   cmd.op = pfgs_pkg::OP_BLK;
			S_NB:    cmd.op = pfgs_pkg::OP_NB;
			S_NBDEC: cmd.cnt_clr = 1'b1;
			S_DIV:   cmd.op = pfgs_pkg::OP_DIV;
			S_REP:   cmd.op = pfgs_pkg::OP_REP;
			S_PICK:  cmd.op = pfgs_pkg::OP_PICK;
			S_FIN:   cmd.op = out_free ? pfgs_pkg::OP_FIN : pfgs_pkg::OP_NONE;
			default: cmd.op = pfgs_pkg::OP_NONE;
		endcase
	end

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			out_valid_q <= 1'b0;
			mark_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					if (sts.cnt_done) begin
						state_q <= mark_q ? S_ACK : S_IDLE;
						mark_q <= 1'b0;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (sts.req == pfgs_pkg::REQ_RESTART) begin
							state_q <= S_CLR;
							mark_q <= 1'b1;
						end else if (sts.req == pfgs_pkg::REQ_STEP) begin
							state_q <= sts.at_goal ? S_GOAL : S_VRD;
						end else begin
							state_q <= S_ACK;
						end
					end
				end
				S_ACK, S_GOAL, S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_VRD: begin
					if (sts.cnt_done) begin
						state_q <= S_MARK;
					end
				end
				S_MARK:  state_q <= sts.no_obs ? S_NB : S_BLK;
				S_BLK: begin
					if (sts.cnt_done) begin
						state_q <= S_NB;
					end
				end
				S_NB:    state_q <= S_NBDEC;
				S_NBDEC: state_q <= (!sts.nb_open || sts.nb_goal) ? S_PICK : S_DIV;
				S_DIV: begin
					if (sts.cnt_done) begin
						state_q <= sts.no_obs ? S_PICK : S_REP;
					end
				end
				S_REP: begin
					if (sts.cnt_done) begin
						state_q <= S_PICK;
					end
				end
				S_PICK:  state_q <= sts.nb_last ? S_FIN : S_NB;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a restart always runs the clearing pass
	a_restart_clr: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && sts.req == pfgs_pkg::REQ_RESTART) |=> (state_q == S_CLR))
		else $error("restart did not start clearing pass");

	// results are loaded only into a free output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == pfgs_pkg::OP_FIN || cmd.op == pfgs_pkg::OP_EMIT_ACK
		|| cmd.op == pfgs_pkg::OP_EMIT_GOAL) |-> out_free)
		else $error("result overwritten before transfer");

	// a new step away from the goal starts from the row reads
	a_step_rows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && sts.req == pfgs_pkg::REQ_STEP && !sts.at_goal) |=> (state_q == S_VRD))
		else $error("step did not start with row reads");

endmodule

`default_nettype wire

// ===== src/potential_field_grid_stepper.sv =====
// potential_field_grid_stepper: top level joining controller and datapath
// depends on pfgs_pkg, pfgs_if, pfgs_ctrl and pfgs_datapath
`timescale 1ns / 1ps
`default_nettype none

// One item is worked on at a time. An obstacle write or an ignored request
// is acknowledged once the result register is free; a restart first runs
// the clearing pass that writes the visited-row memory one row per cycle.
// A step at the goal is answered once the result register is free. Any
// other step reads the visited rows and runs the blocking scan over the N
// active obstacles, then runs the bit-serial attraction divider and the
// obstacle scan per neighbor; a blocked neighbor skips both. After reset
// a clearing pass runs before the first item is taken; configuration
// writes are taken at any time. The result register holds one finished
// result while the next item is accepted.
module potential_field_grid_stepper #(
	parameter int GRID_SIZE     = 64,
	parameter int MAX_OBSTACLES = 6
) (
	input wire logic      clk,
	input wire logic      arst_n,
	pfgs_item_if.sink     item,
	pfgs_result_if.source result,
	pfgs_cfg_if.sink      cfg
);

	pfgs_pkg::dp_cmd_t cmd;
	pfgs_pkg::dp_sts_t sts;
	logic              in_ready;
	logic              out_valid;

	assign item.ready = in_ready;
	assign result.valid = out_valid;
	assign cfg.ready = 1'b1;

	// sequencer
	pfgs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(result.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// datapath
	pfgs_datapath #(
		.GRID_SIZE    (GRID_SIZE),
		.MAX_OBSTACLES(MAX_OBSTACLES)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.in_req  (item.req_type),
		.in_x    (item.pos_x),
		.in_y    (item.pos_y),
		.in_slot (item.slot),
		.cfg_we  (cfg.valid),
		.cfg_idx (cfg.index),
		.cfg_data(cfg.data),
		.res_x   (result.cur_x),
		.res_y   (result.cur_y),
		.res_dir (result.direction),
		.res_st  (result.status)
	);

endmodule

`default_nettype wire
